FILE: rtl/cbfs_pkg.sv
// Package: shared types and codes of the chunked byte find scanner.
`default_nettype none
package cbfs_pkg;

    // Search modes
    localparam logic [1:0] MODE_MEMCHR    = 2'd0;
    localparam logic [1:0] MODE_STRLEN    = 2'd1;
    localparam logic [1:0] MODE_STRCHRNUL = 2'd2;
    localparam logic [1:0] MODE_STRCHR    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BYTE = 1'd1;

    typedef struct packed {
        logic [63:0] chunk_low;
        logic [63:0] chunk_high;
        logic        first_chunk;
        logic [3:0]  start_skip;
        logic [31:0] byte_limit;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] position;
    } t_out_item;

    // Per-chunk controls broadcast to every lane
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] target;
        logic       left_big;   // budget covers every lane of the chunk
    } t_lane_ctl;

endpackage
`default_nettype wire

FILE: rtl/chunked_byte_find_scan.sv
// Top level of the chunked byte find scanner (memchr/strlen/strchrnul/strchr).
`default_nettype none
// Scans a stream of aligned LANES-byte chunks for the lowest matching byte,
// one chunk per clock while the output register is not held by i_out_stall.
// Every input transaction yields exactly one result transaction:
// status pending (search still open, or idle chunk), found with the byte
// offset from the string start, or not found. A chunk with first_chunk set
// opens a new search: lanes below start_skip are masked and, in memchr mode,
// byte_limit is latched as the search budget. The per-chunk work (LANES byte
// compares in parallel lanes, lowest-hit merge, and the one add that carries
// the running offset and budget to the next chunk) all happens in the cycle
// the chunk is accepted, which is what sets the one-chunk-per-cycle rate; the
// saturating position add sits in a second stage ahead of the output
// register. Lanes above byte 15 (LANES > 16) read as NUL. Offsets saturate at
// 0xFFFFFFFF. Write search_mode and target_byte only while the block is idle;
// they apply to every chunk that follows, including mid-search chunks.
module chunked_byte_find_scan #(
    parameter int unsigned LANES = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [cbfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [cbfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // chunk input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire cbfs_pkg::t_in_item                 i_in_data,
    // result output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output cbfs_pkg::t_out_item                     o_out_data
);
    import cbfs_pkg::*;

    localparam int unsigned SPW = $clog2(LANES + 1);  // holds 0..LANES
    localparam int unsigned LIW = $clog2(LANES);      // lane index

    // configuration registers
    logic [1:0] r_mode;
    logic [7:0] r_target;

    // search state
    logic        r_active, n_active;
    logic [31:0] r_bytes_before, n_bytes_before;
    logic [31:0] r_bytes_left, n_bytes_left;

    // stage 1: decision, base offset and hit offset
    logic           r_s1_valid;
    logic [1:0]     r_s1_status, n_s1_status;
    logic [31:0]    r_s1_base, n_s1_base;
    logic [SPW-1:0] r_s1_off, n_s1_off;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data, n_out_data;

    logic in_fire, s1_en, out_en;

    // per-chunk working values
    logic           first;
    logic           work;
    logic [31:0]    skip_ext;
    logic [SPW-1:0] skip_c;
    logic [SPW-1:0] span;
    logic [31:0]    base;
    logic [31:0]    left;
    logic [32:0]    before_sum;
    t_lane_ctl      lane_ctl;

    logic [LANES-1:0] lane_hit;
    logic [LANES-1:0] lane_tgt;
    logic             found;
    logic [LIW-1:0]   found_idx;
    logic             found_tgt;

    logic [32:0] pos_sum;

    // Handshake: the output register advances when empty or taken, stage 1
    // advances when empty or moving on.
    assign out_en      = !r_out_valid || !i_out_stall;
    assign s1_en       = !r_s1_valid || out_en;
    assign o_in_stall  = !s1_en;
    assign in_fire     = i_in_valid && s1_en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MEMCHR;
            r_target <= 8'h00;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SEARCH_MODE: r_mode   <= i_cfg_data[1:0];
                REG_TARGET_BYTE: r_target <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Chunk setup: a first chunk restarts offset and budget, clamp the skip.
    always_comb begin
        first    = i_in_data.first_chunk;
        work     = first || r_active;
        skip_ext = {28'd0, i_in_data.start_skip};
        if (!first) begin
            skip_c = '0;
        end else if (skip_ext >= 32'(LANES)) begin
            skip_c = SPW'(LANES);
        end else begin
            skip_c = skip_ext[SPW-1:0];
        end
        span = SPW'(LANES) - skip_c;
        base = first ? 32'd0 : r_bytes_before;
        left = first ? i_in_data.byte_limit : r_bytes_left;

        lane_ctl.mode     = r_mode;
        lane_ctl.target   = r_target;
        lane_ctl.left_big = (left >= 32'(LANES));
    end

    // Parallel lanes; bytes past the 16-byte chunk read as NUL.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [7:0] lane_byte;
        if (g < 8) begin : g_lo
            assign lane_byte = i_in_data.chunk_low[8*g +: 8];
        end else if (g < 16) begin : g_hi
            assign lane_byte = i_in_data.chunk_high[8*(g-8) +: 8];
        end else begin : g_nul
            assign lane_byte = 8'h00;
        end

        cbfs_lane #(
            .SPW      (SPW),
            .LANE_IDX (g)
        ) u_lane (
            .i_byte      (lane_byte),
            .i_ctl       (lane_ctl),
            .i_skip      (skip_c),
            .i_left_low  (left[SPW-1:0]),
            .o_hit       (lane_hit[g]),
            .o_is_target (lane_tgt[g])
        );
    end

    cbfs_merge #(
        .LANES (LANES),
        .LIW   (LIW)
    ) u_merge (
        .i_hit        (lane_hit),
        .i_is_target  (lane_tgt),
        .o_found      (found),
        .o_idx        (found_idx),
        .o_idx_target (found_tgt)
    );

    // Decide the chunk and carry offset and budget to the next one.
    always_comb begin
        n_active       = r_active;
        n_bytes_before = r_bytes_before;
        n_bytes_left   = r_bytes_left;
        n_s1_status    = ST_PENDING;
        n_s1_base      = 32'd0;
        n_s1_off       = '0;
        before_sum     = {1'b0, base} + 33'(span);

        if (work) begin
            if (found) begin
                // a NUL hit in strchr mode with a nonzero target ends the search empty
                n_active = 1'b0;
                if (r_mode == MODE_STRCHR && !found_tgt) begin
                    n_s1_status = ST_NOTFOUND;
                end else begin
                    n_s1_status = ST_FOUND;
                    n_s1_base   = base;
                    n_s1_off    = SPW'(found_idx) - skip_c;
                end
            end else if (r_mode == MODE_MEMCHR && left <= 32'(span)) begin
                // budget runs out inside this chunk
                n_active    = 1'b0;
                n_s1_status = ST_NOTFOUND;
            end else begin
                n_active       = 1'b1;
                n_bytes_before = before_sum[32] ? 32'hFFFF_FFFF : before_sum[31:0];
                n_bytes_left   = (r_mode == MODE_MEMCHR) ? left - 32'(span) : left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_bytes_before <= 32'd0;
            r_bytes_left   <= 32'd0;
        end else if (in_fire) begin
            r_active       <= n_active;
            r_bytes_before <= n_bytes_before;
            r_bytes_left   <= n_bytes_left;
        end
    end

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_status <= n_s1_status;
            r_s1_base   <= n_s1_base;
            r_s1_off    <= n_s1_off;
        end
    end

    // Stage 2: saturating position add into the output register.
    always_comb begin
        pos_sum             = {1'b0, r_s1_base} + 33'(r_s1_off);
        n_out_data.status   = r_s1_status;
        n_out_data.position = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cbfs_lane.sv
// One byte lane: range mask, budget check and match under the current mode.
`default_nettype none
module cbfs_lane #(
    parameter int unsigned SPW      = 5,
    parameter int unsigned LANE_IDX = 0
) (
    input  wire logic [7:0]         i_byte,
    input  wire cbfs_pkg::t_lane_ctl i_ctl,
    input  wire logic [SPW-1:0]     i_skip,
    input  wire logic [SPW-1:0]     i_left_low,
    output logic                    o_hit,
    output logic                    o_is_target
);
    import cbfs_pkg::*;

    localparam logic [SPW-1:0] IDX = SPW'(LANE_IDX);

    logic           in_range;
    logic [SPW-1:0] off;
    logic           in_budget;
    logic           match;

    always_comb begin
        in_range    = (IDX >= i_skip);
        off         = IDX - i_skip;
        in_budget   = (i_ctl.mode != MODE_MEMCHR) || i_ctl.left_big || (off < i_left_low);
        o_is_target = (i_byte == i_ctl.target);
        case (i_ctl.mode) inside
            MODE_MEMCHR:                 match = o_is_target;
            MODE_STRLEN:                 match = (i_byte == 8'h00);
            MODE_STRCHRNUL, MODE_STRCHR: match = (i_byte == 8'h00) || o_is_target;
            default:                     match = 1'b0;
        endcase
        o_hit = in_range && in_budget && match;
    end

endmodule
`default_nettype wire

FILE: rtl/cbfs_merge.sv
// Lane merge: pick the lowest hitting lane and whether its byte is the target.
`default_nettype none
module cbfs_merge #(
    parameter int unsigned LANES = 16,
    parameter int unsigned LIW   = 4
) (
    input  wire logic [LANES-1:0] i_hit,
    input  wire logic [LANES-1:0] i_is_target,
    output logic                  o_found,
    output logic [LIW-1:0]        o_idx,
    output logic                  o_idx_target
);
    always_comb begin
        o_found      = 1'b0;
        o_idx        = '0;
        o_idx_target = 1'b0;
        // scan from the top so the lowest hit wins
        for (int i = LANES - 1; i >= 0; i--) begin
            if (i_hit[i]) begin
                o_found      = 1'b1;
                o_idx        = LIW'(i);
                o_idx_target = i_is_target[i];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cbfs_checker.sv
// Port-level checker for the chunked byte find scanner, bound to the top level.
`default_nettype none
module cbfs_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire cbfs_pkg::t_out_item o_out_data
);
    import cbfs_pkg::*;

    // Output register comes up empty out of reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An empty output register means the whole pipe can move: no input stall.
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output register empty");

    // Status is a legal code, and only a found result carries a position.
    a_status_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3) &&
                        (o_out_data.status == ST_FOUND || o_out_data.position == 32'd0))
        else $error("bad status or stray position");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind chunked_byte_find_scan cbfs_checker u_cbfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

FILE: tb/sv/chunked_byte_find_scan_tb.sv
// Testbench for chunked_byte_find_scan: directed and random chunk streams checked by a scan model.
module chunked_byte_find_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbfs_pkg::*;

    localparam int unsigned LANES = 16;
    // Lane marker for chunk_of(): leave every lane at its fill byte
    localparam int NO_LANE = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;

    // Chunks waiting for the driver, and scan results still owed by the block
    t_in_item  chunks_to_send[$];
    t_out_item scan_results_due[$];

    int issued_count = 0;
    int accepted_count = 0;
    int fail_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Scan model state: running offset of lane 0, memchr budget, open search flag
    logic [31:0] scan_offset = '0;
    logic [31:0] scan_budget = '0;
    logic        scan_open = 1'b0;
    // Model copy of the registers
    logic [1:0]  mode_q = MODE_MEMCHR;
    logic [7:0]  target_q = 8'h00;

    chunked_byte_find_scan #(
        .LANES(LANES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Scan one accepted chunk: update the search state, return the result it causes
    function automatic t_out_item scan_chunk(input t_in_item c);
        t_out_item   r;
        logic [127:0] lanes;
        logic [7:0]  b;
        logic [31:0] off;
        int unsigned skip;
        logic        hit;
        r = '0;
        skip = 0;
        lanes = {c.chunk_high, c.chunk_low};
        if (c.first_chunk) begin
            // open a new search: mask leading lanes, latch the budget
            scan_open = 1'b1;
            skip = {28'd0, c.start_skip};
            scan_offset = '0;
            scan_budget = c.byte_limit;
        end else if (!scan_open) begin
            // idle chunk: report pending, change nothing
            return r;
        end
        if (skip > LANES) skip = LANES;
        for (int unsigned i = skip; i < LANES; i++) begin
            // lanes above byte 15 read as NUL
            b = (i < 16) ? lanes[8*i +: 8] : 8'h00;
            off = i - skip;
            if (mode_q == MODE_MEMCHR) begin
                if (off >= scan_budget) break;
                hit = (b == target_q);
            end else if (mode_q == MODE_STRLEN) begin
                hit = (b == 8'h00);
            end else begin
                hit = (b == 8'h00) || (b == target_q);
            end
            if (hit) begin
                scan_open = 1'b0;
                if (mode_q == MODE_STRCHR && b != target_q) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.status = ST_FOUND;
                    r.position = add_sat(scan_offset, off);
                end
                return r;
            end
        end
        if (mode_q == MODE_MEMCHR) begin
            // budget runs out inside this chunk: decide now
            if (scan_budget <= LANES - skip) begin
                scan_open = 1'b0;
                r.status = ST_NOTFOUND;
                return r;
            end
            scan_budget = scan_budget - (LANES - skip);
        end
        scan_offset = add_sat(scan_offset, LANES - skip);
        return r;
    endfunction

    // Build a chunk from a fill byte with up to two placed bytes
    function automatic t_in_item chunk_of(input logic [7:0] fill,
                                          input int lane_a, input logic [7:0] byte_a,
                                          input int lane_b, input logic [7:0] byte_b,
                                          input logic first, input logic [3:0] skip,
                                          input logic [31:0] limit);
        t_in_item     c;
        logic [127:0] bytes;
        bytes = {16{fill}};
        if (lane_a < 16) bytes[8*lane_a +: 8] = byte_a;
        if (lane_b < 16) bytes[8*lane_b +: 8] = byte_b;
        c.chunk_low = bytes[63:0];
        c.chunk_high = bytes[127:64];
        c.first_chunk = first;
        c.start_skip = skip;
        c.byte_limit = limit;
        return c;
    endfunction

    // Bias bytes toward NUL and the target so searches end within a few chunks
    function automatic logic [7:0] pick_byte();
        int unsigned roll;
        roll = $urandom_range(63);
        if (roll == 0) return 8'h00;
        if (roll == 1) return target_q;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(3))
            0: return 32'($urandom_range(48));
            1: return 32'($urandom_range(16));
            2: return 32'($urandom);
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic t_in_item random_chunk(input logic first, input logic [3:0] skip,
                                              input logic [31:0] limit);
        t_in_item     c;
        logic [127:0] bytes;
        for (int i = 0; i < 16; i++) bytes[8*i +: 8] = pick_byte();
        c.chunk_low = bytes[63:0];
        c.chunk_high = bytes[127:64];
        c.first_chunk = first;
        c.start_skip = skip;
        c.byte_limit = limit;
        return c;
    endfunction

    // Queue searches (a first chunk plus a few follow-on chunks) mixed with noise.
    // Only chunks of searches count toward the quota.
    task automatic queue_search_traffic(input int quota);
        int       made;
        int       roll;
        int       tail;
        t_in_item c;
        made = 0;
        while (made < quota) begin
            roll = $urandom_range(99);
            if (roll < 85) begin
                chunks_to_send.push_back(random_chunk(1'b1, 4'($urandom_range(15)),
                                                      pick_limit()));
                made++;
                tail = $urandom_range(4);
                repeat (tail) begin
                    // skip and limit are ignored on follow-on chunks: randomize them anyway
                    chunks_to_send.push_back(random_chunk(1'b0, 4'($urandom_range(15)),
                                                          32'($urandom)));
                    made++;
                end
            end else if (roll < 93) begin
                // stray follow-on chunk: idle chunk unless a search is still open
                chunks_to_send.push_back(random_chunk(1'b0, 4'($urandom_range(15)),
                                                      32'($urandom)));
            end else begin
                // raw noise over every bit, first_chunk included
                c.chunk_low = {$urandom, $urandom};
                c.chunk_high = {$urandom, $urandom};
                c.first_chunk = 1'($urandom_range(1));
                c.start_skip = 4'($urandom_range(15));
                c.byte_limit = 32'($urandom);
                chunks_to_send.push_back(c);
            end
        end
    endtask

    // Write one register at a falling edge, then mirror it in the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_SEARCH_MODE) mode_q = val[1:0];
        else target_q = val;
    endtask

    // Hold until every queued chunk is taken and every result is back, then drain the pipe
    task automatic wait_idle();
        while (chunks_to_send.size() != 0 || accepted_count != issued_count
               || scan_results_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Driver: present a new chunk only once the current one has been taken;
    // a stalled transaction holds its payload.
    always @(negedge i_clk) begin
        if (i_rst_n && accepted_count == issued_count) begin
            if (chunks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_data <= chunks_to_send.pop_front();
                in_valid <= 1'b1;
                issued_count++;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // Monitor: check each result transaction against the oldest one due,
    // then run the model on an accepted chunk transaction.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (scan_results_due.size() == 0) begin
                    $display("%0t: unexpected result: status %0d position %0d",
                             $time, out_data.status, out_data.position);
                    fail_count++;
                end else begin
                    want = scan_results_due.pop_front();
                    if (out_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.position !== want.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, out_data.position);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                scan_results_due.push_back(scan_chunk(in_data));
                accepted_count++;
            end
        end
    end

    initial begin : stimulus
        logic [1:0] mode_pick;
        logic [7:0] target_pick;

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // memchr: zero limit, masked hit, target just past the limit, hit across chunks, idle chunk
        write_reg(REG_SEARCH_MODE, {6'd0, MODE_MEMCHR});
        write_reg(REG_TARGET_BYTE, 8'h5A);
        chunks_to_send.push_back(chunk_of(8'h5A, NO_LANE, 8'h00, NO_LANE, 8'h00, 1'b1, 4'd0, 32'd0));
        chunks_to_send.push_back(chunk_of(8'h00, 1, 8'h5A, 6, 8'h5A, 1'b1, 4'd3, 32'd100));
        chunks_to_send.push_back(chunk_of(8'h11, NO_LANE, 8'h00, NO_LANE, 8'h00, 1'b1, 4'd15, 32'd5));
        chunks_to_send.push_back(chunk_of(8'h11, 4, 8'h5A, NO_LANE, 8'h00, 1'b0, 4'd0, 32'd0));
        chunks_to_send.push_back(chunk_of(8'hFF, NO_LANE, 8'h00, NO_LANE, 8'h00, 1'b1, 4'd0, 32'd20));
        chunks_to_send.push_back(chunk_of(8'h00, 3, 8'h5A, NO_LANE, 8'h00, 1'b0, 4'd0, 32'd0));
        chunks_to_send.push_back(chunk_of(8'h5A, NO_LANE, 8'h00, NO_LANE, 8'h00, 1'b0, 4'd0, 32'd0));
        // all-ones and all-zeros chunks, largest skip and limit
        chunks_to_send.push_back(chunk_of(8'hFF, NO_LANE, 8'h00, NO_LANE, 8'h00, 1'b1, 4'd15,
                                          32'hFFFF_FFFF));
        chunks_to_send.push_back(chunk_of(8'h00, NO_LANE, 8'h00, NO_LANE, 8'h00, 1'b0, 4'd15,
                                          32'hFFFF_FFFF));
        chunks_to_send.push_back(chunk_of(8'h00, 15, 8'h5A, NO_LANE, 8'h00, 1'b0, 4'd0, 32'd0));
        wait_idle();

        // strlen: NUL in the last lane, NUL in a masked lane
        write_reg(REG_SEARCH_MODE, {6'd0, MODE_STRLEN});
        write_reg(REG_TARGET_BYTE, 8'hFF);
        chunks_to_send.push_back(chunk_of(8'hFF, 15, 8'h00, NO_LANE, 8'h00, 1'b1, 4'd0, 32'd0));
        chunks_to_send.push_back(chunk_of(8'h41, 2, 8'h00, 9, 8'h00, 1'b1, 4'd7, 32'd0));
        wait_idle();

        // strchrnul: NUL first, target first, restart while a search is open
        write_reg(REG_SEARCH_MODE, {6'd0, MODE_STRCHRNUL});
        write_reg(REG_TARGET_BYTE, 8'h80);
        chunks_to_send.push_back(chunk_of(8'h41, 5, 8'h00, 9, 8'h80, 1'b1, 4'd0, 32'd0));
        chunks_to_send.push_back(chunk_of(8'h41, 4, 8'h80, 9, 8'h00, 1'b1, 4'd1, 32'd0));
        chunks_to_send.push_back(chunk_of(8'h41, NO_LANE, 8'h00, NO_LANE, 8'h00, 1'b1, 4'd0, 32'd0));
        chunks_to_send.push_back(chunk_of(8'h41, 0, 8'h80, NO_LANE, 8'h00, 1'b1, 4'd0, 32'd0));
        wait_idle();

        // strchr: NUL before the target is not found, target first is found
        write_reg(REG_SEARCH_MODE, {6'd0, MODE_STRCHR});
        write_reg(REG_TARGET_BYTE, 8'h41);
        chunks_to_send.push_back(chunk_of(8'h33, 6, 8'h00, 8, 8'h41, 1'b1, 4'd0, 32'd0));
        chunks_to_send.push_back(chunk_of(8'h33, 8, 8'h41, 12, 8'h00, 1'b1, 4'd0, 32'd0));
        chunks_to_send.push_back(chunk_of(8'h41, NO_LANE, 8'h00, NO_LANE, 8'h00, 1'b0, 4'd0, 32'd0));
        wait_idle();

        // strchr with target NUL: the NUL hit is the target itself
        write_reg(REG_TARGET_BYTE, 8'h00);
        chunks_to_send.push_back(chunk_of(8'h33, 10, 8'h00, NO_LANE, 8'h00, 1'b1, 4'd2, 32'd0));
        wait_idle();

        // Random phases: rotate idling pattern, mode and target. A phase may end with
        // a search still open, so the next phase's writes land mid-search.
        for (int k = 0; k < 16; k++) begin
            case (k % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            mode_pick = (k < 8) ? 2'(k % 4) : 2'($urandom_range(3));
            case (k % 3)
                0: target_pick = 8'h00;
                1: target_pick = 8'hFF;
                default: target_pick = 8'($urandom_range(255));
            endcase
            // upper bits of the mode write are don't-care: randomize them
            write_reg(REG_SEARCH_MODE, {6'($urandom_range(63)), mode_pick});
            write_reg(REG_TARGET_BYTE, target_pick);
            queue_search_traffic(60);
            wait_idle();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS chunked_byte_find_scan");
        end else begin
            $display("FAIL chunked_byte_find_scan");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("FAIL chunked_byte_find_scan");
        $finish;
    end

endmodule
